### rtl/cartridge_bank_mapper_macros.svh
// assertion macros for the cartridge bank mapper checker
// expects clk and arst_n in the scope of each use
`ifndef CARTRIDGE_BANK_MAPPER_MACROS_SVH
`define CARTRIDGE_BANK_MAPPER_MACROS_SVH

// property must hold at every clock edge outside reset
`define CBM_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) \
		else $error(msg);

// expression must never be true outside reset
`define CBM_NEVER(lbl, expr, msg) `CBM_ASSERT(lbl, !(expr), msg)

`endif

### rtl/cbm_pkg.sv
// shared types, constants and helper function of the cartridge bank mapper
// no dependencies
package cbm_pkg;

	localparam int RAM_BYTES      = 32768;
	localparam int ROM_BANKS_MAX  = 128;
	localparam int RAM_BANK_BYTES = 8192;
	localparam int RAM_AW         = $clog2(RAM_BYTES);
	localparam int RAM_BANKS_FIT  = RAM_BYTES / RAM_BANK_BYTES;
	localparam int RAM_BANKS_LIM  = (RAM_BANKS_FIT < 4) ? RAM_BANKS_FIT : 4;
	localparam int CFG_IDX_W      = 1;
	localparam int CFG_DATA_W     = 8;

	typedef enum logic [1:0] {
		KIND_WRITE = 2'd0,
		KIND_ROM   = 2'd1,
		KIND_DATA  = 2'd2
	} kind_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_ROM_BANKS = 1'b0,
		CFG_RAM_BANKS = 1'b1
	} cfg_idx_t;

	// control register select, address bits 14:13 of a write below 0x8000
	typedef enum logic [1:0] {
		SEL_RAM_EN   = 2'd0,
		SEL_ROM_BANK = 2'd1,
		SEL_UPPER    = 2'd2,
		SEL_MODE     = 2'd3
	} ctl_sel_t;

	typedef enum logic {
		ST_IDLE,
		ST_FINISH
	} st_t;

	typedef struct packed {
		logic        mode;
		logic [15:0] address;
		logic [7:0]  write_data;
	} req_t;

	typedef struct packed {
		kind_t       read_kind;
		logic [20:0] rom_address;
		logic [7:0]  read_data;
	} rsp_t;

	typedef struct packed {
		logic       valid;
		ctl_sel_t   sel;
		logic [7:0] data;
	} ctl_wr_t;

	typedef struct packed {
		logic       ram_enable;
		logic [4:0] low_rom_bank;
		logic [1:0] upper_bank;
		logic       bank_mode;
		logic [7:0] rom_div;
		logic [2:0] ram_banks;
	} bank_state_t;

	// one restoring remainder step: shift in a dividend bit, subtract if it fits
	function automatic logic [7:0] rem_step(input logic [7:0] r, input logic b,
			input logic [7:0] d);
		logic [7:0] t;
		t = {r[6:0], b};
		return (t >= d) ? (t - d) : t;
	endfunction

endpackage

### rtl/cbm_bank_regs.sv
// control and configuration registers of the cartridge bank mapper
// depends on cbm_pkg
module cbm_bank_regs import cbm_pkg::*; (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data,
	input  ctl_wr_t               ctl_wr,
	output bank_state_t           bst
);

	logic [7:0] rom_cnt_q;
	logic [2:0] ram_cnt_q;
	logic       ram_en_q;
	logic [4:0] low_bank_q;
	logic [1:0] upper_q;
	logic       mode_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rom_cnt_q <= 8'd2;
			ram_cnt_q <= 3'd1;
		end else if (cfg_we) begin
			unique case (cfg_idx_t'(cfg_index))
				CFG_ROM_BANKS: rom_cnt_q <= cfg_data[7:0];
				CFG_RAM_BANKS: ram_cnt_q <= cfg_data[2:0];
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ram_en_q   <= 1'b0;
			low_bank_q <= 5'd1;
			upper_q    <= 2'd0;
			mode_q     <= 1'b0;
		end else if (ctl_wr.valid) begin
			unique case (ctl_wr.sel)
				SEL_RAM_EN:   ram_en_q <= (ctl_wr.data[3:0] == 4'hA);
				SEL_ROM_BANK: low_bank_q <= (ctl_wr.data[4:0] == 5'd0) ? 5'd1
							: ctl_wr.data[4:0];
				SEL_UPPER:    upper_q <= ctl_wr.data[1:0];
				SEL_MODE:     mode_q <= ctl_wr.data[0];
				default:      mode_q <= mode_q;
			endcase
		end
	end

	always_comb begin
		bst.ram_enable   = ram_en_q;
		bst.low_rom_bank = low_bank_q;
		bst.upper_bank   = upper_q;
		bst.bank_mode    = mode_q;
		// zero acts as one bank, oversized counts clamp
		if (rom_cnt_q == 8'd0)
			bst.rom_div = 8'd1;
		else if (rom_cnt_q > 8'(ROM_BANKS_MAX))
			bst.rom_div = 8'(ROM_BANKS_MAX);
		else
			bst.rom_div = rom_cnt_q;
		if (ram_cnt_q == 3'd0)
			bst.ram_banks = 3'd1;
		else if (ram_cnt_q > 3'(RAM_BANKS_LIM))
			bst.ram_banks = 3'(RAM_BANKS_LIM);
		else
			bst.ram_banks = ram_cnt_q;
	end

endmodule

### rtl/cartridge_bank_mapper.sv
// cartridge bank mapper top level: bank registers, cartridge ram, remainder unit
// one request at a time: on accept the request, the upper steps of the split rom bank
// remainder and the synchronous ram read are registered; the response then goes to the
// output register once it is free, and loading it frees the next accept
// reset: bank registers to power-on values, no request in flight; ram holds garbage
// depends on cbm_pkg and cbm_bank_regs
module cartridge_bank_mapper import cbm_pkg::*; (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  req_valid,
	output logic                  req_ready,
	input  req_t                  req,
	output logic                  rsp_valid,
	input  logic                  rsp_ready,
	output rsp_t                  rsp,
	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data
);

	// ram bank reduced modulo the effective ram bank count (1 to 4)
	function automatic logic [1:0] ram_bank_mod(input logic [1:0] u, input logic [2:0] n);
		logic [1:0] m;
		unique case (n)
			3'd1:    m = 2'd0;
			3'd2:    m = {1'b0, u[0]};
			3'd3:    m = (u == 2'd3) ? 2'd0 : u;
			default: m = u;
		endcase
		return m;
	endfunction

	bank_state_t bst;
	ctl_wr_t     ctl_wr;
	st_t         state_q, state_d;

	logic        req_fire;
	logic        rsp_load;
	logic        ram_hit;
	logic [1:0]  ram_bank;
	logic [RAM_AW-1:0] ram_idx;
	logic [6:0]  rom_bank;
	logic [7:0]  rem_hi;
	logic [7:0]  rem_lo;
	kind_t       kind_in;
	rsp_t        rsp_d;

	// first stage holds the request and the remainder after the upper four steps
	kind_t       kind_s1;
	logic [13:0] offs_s1;
	logic [7:0]  rem_s1;
	logic [2:0]  bank_lo_s1;
	logic        ram_hit_s1;

	logic [7:0]  cart_ram [RAM_BYTES];
	logic [7:0]  ram_rd_q;

	logic        rsp_valid_q;
	rsp_t        rsp_q;

	assign req_fire = req_valid && req_ready;

	// control writes below 0x8000 go to the bank registers on accept
	assign ctl_wr.valid = req_fire && req.mode && !req.address[15];
	assign ctl_wr.sel   = ctl_sel_t'(req.address[14:13]);
	assign ctl_wr.data  = req.write_data;

	cbm_bank_regs u_regs (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.ctl_wr    (ctl_wr),
		.bst       (bst)
	);

	// cartridge ram window 0xa000-0xbfff, live only while enabled
	assign ram_hit  = (req.address[15:13] == 3'b101) && bst.ram_enable;
	assign ram_bank = bst.bank_mode ? ram_bank_mod(bst.upper_bank, bst.ram_banks) : 2'd0;
	assign ram_idx  = RAM_AW'({ram_bank, req.address[12:0]});

	// rom bank before reduction: lower window uses upper bits only in mode 1
	always_comb begin
		if (req.address[14])
			rom_bank = {bst.upper_bank, bst.low_rom_bank};
		else if (bst.bank_mode)
			rom_bank = {bst.upper_bank, 5'd0};
		else
			rom_bank = 7'd0;
	end

	// upper four remainder steps in the accept cycle
	always_comb begin
		rem_hi = 8'd0;
		for (int i = 6; i >= 3; i--)
			rem_hi = rem_step(rem_hi, rom_bank[i], bst.rom_div);
	end

	always_comb begin
		if (req.mode)
			kind_in = KIND_WRITE;
		else if (!req.address[15])
			kind_in = KIND_ROM;
		else
			kind_in = KIND_DATA;
	end

	always_ff @(posedge clk) begin
		if (req_fire) begin
			kind_s1    <= kind_in;
			offs_s1    <= req.address[13:0];
			rem_s1     <= rem_hi;
			bank_lo_s1 <= rom_bank[2:0];
			ram_hit_s1 <= ram_hit;
		end
	end

	// single-port ram: write on an enabled ram write, read on every accept;
	// one request at a time, so no read ever overlaps a pending write
	always_ff @(posedge clk) begin
		if (req_fire) begin
			if (req.mode && ram_hit)
				cart_ram[ram_idx] <= req.write_data;
			ram_rd_q <= cart_ram[ram_idx];
		end
	end

	// lower three remainder steps, then form the response
	always_comb begin
		rem_lo = rem_s1;
		for (int i = 2; i >= 0; i--)
			rem_lo = rem_step(rem_lo, bank_lo_s1[i], bst.rom_div);
	end

	always_comb begin
		rsp_d.read_kind   = kind_s1;
		rsp_d.rom_address = 21'd0;
		rsp_d.read_data   = 8'd0;
		unique case (kind_s1)
			KIND_ROM:  rsp_d.rom_address = {rem_lo[6:0], offs_s1};
			KIND_DATA: rsp_d.read_data = ram_hit_s1 ? ram_rd_q : 8'hFF;
			default:   rsp_d.read_kind = KIND_WRITE;
		endcase
	end

	// sequencer: accept in idle, finish once the output register is free
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			state_q <= ST_IDLE;
		else
			state_q <= state_d;
	end

	always_comb begin
		state_d   = state_q;
		req_ready = 1'b0;
		rsp_load  = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				req_ready = 1'b1;
				if (req_valid)
					state_d = ST_FINISH;
			end
			ST_FINISH: begin
				if (!rsp_valid_q || rsp_ready) begin
					rsp_load = 1'b1;
					state_d  = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	// output register decouples the response side from the next accept
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			rsp_valid_q <= 1'b0;
		else if (rsp_load)
			rsp_valid_q <= 1'b1;
		else if (rsp_ready)
			rsp_valid_q <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (rsp_load)
			rsp_q <= rsp_d;
	end

	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

endmodule

### rtl/cbm_checker.sv
// port-level checks of the cartridge bank mapper, bound to the top level
// depends on cbm_pkg and cartridge_bank_mapper_macros.svh
`include "cartridge_bank_mapper_macros.svh"

module cbm_checker import cbm_pkg::*; (
	input logic clk,
	input logic arst_n,
	input logic req_valid,
	input logic req_ready,
	input logic rsp_valid,
	input logic rsp_ready,
	input rsp_t rsp
);

	`CBM_ASSERT(a_rsp_hold, rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp), "response changed while stalled")
	`CBM_ASSERT(a_one_in_flight, req_valid && req_ready |=> !req_ready, "second request taken while busy")
	`CBM_ASSERT(a_rom_addr_clear, rsp_valid && rsp.read_kind != KIND_ROM |-> rsp.rom_address == 21'd0, "rom address set on non-rom response")
	`CBM_NEVER(a_rom_no_data, rsp_valid && rsp.read_kind == KIND_ROM && rsp.read_data != 8'd0, "data set on rom response")

endmodule

bind cartridge_bank_mapper cbm_checker u_cbm_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.req_valid (req_valid),
	.req_ready (req_ready),
	.rsp_valid (rsp_valid),
	.rsp_ready (rsp_ready),
	.rsp       (rsp)
);
